>>> src/byte_alu_add_sub_binary_bcd_defines.svh
`ifndef BYTE_ALU_ADD_SUB_BINARY_BCD_DEFINES_SVH
`define BYTE_ALU_ADD_SUB_BINARY_BCD_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BAAB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BAAB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/baab_pkg.sv
package baab_pkg;

    typedef enum logic [1:0] {
        CMD_BIN_ADD = 2'd0,
        CMD_BIN_SUB = 2'd1,
        CMD_DEC_ADD = 2'd2,
        CMD_DEC_SUB = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       carry_out;
        logic       negative;
        logic       zero;
        logic       overflow;
        logic       flags_written;
    } t_alu_res;

    localparam logic [4:0] DEC_DIGIT_MAX = 5'd9;
    localparam logic [4:0] DEC_BASE      = 5'd10;
    localparam logic [7:0] DSUB_LO_FIX   = 8'h06;
    localparam logic [7:0] DSUB_HI_FIX   = 8'h60;

endpackage

>>> src/byte_alu_add_sub_binary_bcd.sv
// Byte add/subtract-with-carry unit with binary and decimal modes. A word is
// taken on every rising edge at which start is high; busy stays low, so a new
// word may be issued every cycle. Each taken word passes one input register
// and then one result register on its way to the outputs, and its result is
// shown for exactly one cycle with o_result_valid high. The receiver cannot
// stall the unit and must capture every result in the cycle it is shown.
// In the decimal modes o_flags_written is low and the N, Z and V outputs are
// zero, meaning the caller keeps its previous flags.
`include "byte_alu_add_sub_binary_bcd_defines.svh"

module byte_alu_add_sub_binary_bcd (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic       i_carry_in,
    output logic       o_result_valid,
    output logic [7:0] o_result_byte,
    output logic       o_carry_out,
    output logic       o_negative,
    output logic       o_zero,
    output logic       o_overflow,
    output logic       o_flags_written
);
    import baab_pkg::*;

    logic       r_in_vld;
    logic       n_in_vld;
    t_cmd       r_cmd;
    logic [7:0] r_a;
    logic [7:0] r_b;
    logic       r_c;
    logic       r_out_vld;
    t_alu_res   r_res;
    t_alu_res   w_res;

    assign busy     = 1'b0;
    assign n_in_vld = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_cmd <= t_cmd'(i_cmd);
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
            r_c   <= i_carry_in;
        end
        if (r_in_vld) begin
            r_res <= w_res;
        end
    end

    baab_core u_core (
        .i_cmd       (r_cmd),
        .i_operand_a (r_a),
        .i_operand_b (r_b),
        .i_carry_in  (r_c),
        .o_res       (w_res)
    );

    assign o_result_valid  = r_out_vld;
    assign o_result_byte   = r_res.result_byte;
    assign o_carry_out     = r_res.carry_out;
    assign o_negative      = r_res.negative;
    assign o_zero          = r_res.zero;
    assign o_overflow      = r_res.overflow;
    assign o_flags_written = r_res.flags_written;

    `BAAB_ASSERT_NEXT(a_stage_adv, i_clk, i_rst_n, r_in_vld, o_result_valid, "accepted word lost between stages")
    `BAAB_ASSERT_IMPLY(a_res_origin, i_clk, i_rst_n, o_result_valid, $past(start, 2), "result without an accepted word")
    `BAAB_ASSERT_IMPLY(a_dec_flags, i_clk, i_rst_n, o_result_valid && !o_flags_written, !o_negative && !o_zero && !o_overflow, "decimal result carries flags")
    `BAAB_ASSERT_IMPLY(a_zero_flag, i_clk, i_rst_n, o_result_valid && o_flags_written, o_zero == (o_result_byte == 8'h00), "zero flag disagrees with result")

endmodule

>>> src/baab_core.sv
module baab_core (
    input  baab_pkg::t_cmd     i_cmd,
    input  logic [7:0]         i_operand_a,
    input  logic [7:0]         i_operand_b,
    input  logic               i_carry_in,
    output baab_pkg::t_alu_res o_res
);
    import baab_pkg::*;

    logic [7:0] w_b_op;
    logic [8:0] w_bsum;
    logic       w_bin_v;

    logic [4:0] w_lo_sum;
    logic       w_lo_cy;
    logic [4:0] w_lo_adj;
    logic [4:0] w_hi_sum;
    logic       w_hi_cy;
    logic [4:0] w_hi_adj;
    logic [7:0] w_dadd;

    logic [7:0] w_ds1;
    logic [7:0] w_ds2;
    logic [7:0] w_ds3;
    logic [7:0] w_ds4;

    // Binary subtract is an add of the inverted operand with carry as not-borrow.
    assign w_b_op  = (i_cmd == CMD_BIN_SUB) ? ~i_operand_b : i_operand_b;
    assign w_bsum  = {1'b0, i_operand_a} + {1'b0, w_b_op} + {8'b0, i_carry_in};
    assign w_bin_v = (i_operand_a[7] == w_b_op[7]) && (w_bsum[7] != i_operand_a[7]);

    assign w_lo_sum = {4'b0, i_carry_in} + {1'b0, i_operand_a[3:0]} + {1'b0, i_operand_b[3:0]};
    assign w_lo_cy  = w_lo_sum > DEC_DIGIT_MAX;
    assign w_lo_adj = w_lo_cy ? (w_lo_sum - DEC_BASE) : w_lo_sum;
    assign w_hi_sum = {4'b0, w_lo_cy} + {1'b0, i_operand_a[7:4]} + {1'b0, i_operand_b[7:4]};
    assign w_hi_cy  = w_hi_sum > DEC_DIGIT_MAX;
    assign w_hi_adj = w_hi_cy ? (w_hi_sum - DEC_BASE) : w_hi_sum;
    assign w_dadd   = {3'b0, w_lo_adj} + {w_hi_adj[3:0], 4'b0};

    assign w_ds1 = i_operand_a + ~{4'b0, i_operand_b[3:0]} + {7'b0, i_carry_in};
    assign w_ds2 = (w_ds1[3:0] > i_operand_a[3:0]) ? (w_ds1 - DSUB_LO_FIX) : w_ds1;
    assign w_ds3 = w_ds2 - {i_operand_b[7:4], 4'b0};
    assign w_ds4 = (w_ds3[7:4] > i_operand_a[7:4]) ? (w_ds3 - DSUB_HI_FIX) : w_ds3;

    always_comb begin
        o_res = '0;
        unique case (i_cmd)
            CMD_BIN_ADD, CMD_BIN_SUB: begin
                o_res.result_byte   = w_bsum[7:0];
                o_res.carry_out     = w_bsum[8];
                o_res.negative      = w_bsum[7];
                o_res.zero          = (w_bsum[7:0] == 8'h00);
                o_res.overflow      = w_bin_v;
                o_res.flags_written = 1'b1;
            end
            CMD_DEC_ADD: begin
                o_res.result_byte = w_dadd;
                o_res.carry_out   = w_hi_cy;
            end
            CMD_DEC_SUB: begin
                o_res.result_byte = w_ds4;
                o_res.carry_out   = !(w_ds4 > i_operand_a);
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule
